/* rtl/fcdd_pkg.sv */
// fcdd_pkg: types, codes and a helper function shared by the deframer/decoder
// no dependencies

package fcdd_pkg;

   localparam logic [7:0] MARKER_BYTE = 8'hFF;
   localparam logic [7:0] MAX_ANGLE_RESET = 8'd180;

   localparam logic [7:0] CMD_MOTOR = 8'h00;
   localparam logic [7:0] CMD_SERVO = 8'h01;
   localparam logic [7:0] CMD_DUTY = 8'h02;
   localparam logic [7:0] CMD_LIGHT = 8'h04;
   localparam logic [7:0] CMD_BUZZER = 8'h05;
   localparam logic [7:0] CMD_IR_LEARN = 8'h50;
   localparam logic [7:0] CMD_IR_SEND = 8'h51;
   localparam logic [7:0] CMD_MODE = 8'h13;
   localparam logic [7:0] CMD_STORE = 8'h32;

   localparam logic [3:0] ACT_MOTOR = 4'd0;
   localparam logic [3:0] ACT_SERVO = 4'd1;
   localparam logic [3:0] ACT_DUTY = 4'd2;
   localparam logic [3:0] ACT_LIGHT = 4'd3;
   localparam logic [3:0] ACT_BUZZER = 4'd4;
   localparam logic [3:0] ACT_IR_LEARN = 4'd5;
   localparam logic [3:0] ACT_IR_SEND = 4'd6;
   localparam logic [3:0] ACT_MODE = 4'd7;
   localparam logic [3:0] ACT_STORE = 4'd8;

   localparam logic [7:0] MAX_MOTOR_DIR = 8'd4;
   localparam logic [7:0] MAX_SERVO_IDX = 8'd8;
   localparam logic [7:0] IR_TYPE_LIMIT = 8'd5;
   localparam logic [7:0] IR_NUM_LIMIT = 8'd10;
   localparam logic [7:0] MAX_MODE = 8'd6;

   localparam logic [2:0] FRAME_LEN = 3'd3;
   localparam logic [2:0] COUNT_SAT = 3'd4;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_OPEN,
      KIND_CLOSE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } task_type;

   typedef struct packed {
      logic       frame_done;
      logic       restart_timeout;
      logic [3:0] action;
      logic [2:0] motor_dir;
      logic [2:0] run_status;
      logic [2:0] channel;
      logic [7:0] value;
   } result_type;

   function automatic logic [2:0] status_of_dir(input logic [2:0] dir);
      logic [2:0] st;
      unique case (dir)
         3'd0: st = 3'd4;
         3'd1: st = 3'd3;
         3'd2: st = 3'd5;
         3'd3: st = 3'd2;
         3'd4: st = 3'd1;
         default: st = 3'd0;
      endcase
      return st;
   endfunction

endpackage

/* rtl/fcdd_front.sv */
// fcdd_front: frame tracker, classifies each byte and stores the payload
// depends on fcdd_pkg

module fcdd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          rx_byte,
   output fcdd_pkg::task_type  task_out
);
   import fcdd_pkg::*;

   logic       receiving_ff, receiving_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] buf_ff [3];
   logic       is_marker;

   assign is_marker = (rx_byte == MARKER_BYTE);

   always_comb begin
      receiving_in = receiving_ff;
      count_in = count_ff;
      task_out.kind = KIND_NONE;
      task_out.b0 = buf_ff[0];
      task_out.b1 = buf_ff[1];
      task_out.b2 = buf_ff[2];
      if (!receiving_ff) begin
         if (is_marker) begin
            receiving_in = 1'b1;
            count_in = 3'd0;
            task_out.kind = KIND_OPEN;
         end
      end else if (is_marker) begin
         receiving_in = 1'b0;
         count_in = 3'd0;
         if (count_ff == FRAME_LEN) begin
            task_out.kind = KIND_CLOSE;
         end
      end else if (count_ff < COUNT_SAT) begin
         count_in = count_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         count_ff <= 3'd0;
      end else if (byte_valid) begin
         receiving_ff <= receiving_in;
         count_ff <= count_in;
      end
   end

   // payload store
   always_ff @(posedge clock) begin
      if (byte_valid && receiving_ff && !is_marker && count_ff < FRAME_LEN) begin
         buf_ff[count_ff[1:0]] <= rx_byte;
      end
   end

endmodule

/* rtl/fcdd_fifo.sv */
// fcdd_fifo: two-entry transaction queue between front and back
// depends on fcdd_pkg

module fcdd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fcdd_pkg::task_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output fcdd_pkg::task_type  head
);
   import fcdd_pkg::*;

   task_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/fcdd_back.sv */
// fcdd_back: command decoder and output register
// depends on fcdd_pkg

module fcdd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                task_valid,
   input  fcdd_pkg::task_type  task_in,
   output logic                task_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output fcdd_pkg::result_type out_data
);
   import fcdd_pkg::*;

   logic [7:0] max_angle_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type res;
   logic       ok;
   logic [7:0] b0, b1, b2;

   assign b0 = task_in.b0;
   assign b1 = task_in.b1;
   assign b2 = task_in.b2;

   assign task_pop = task_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_data = out_ff;

   always_comb begin
      res = '0;
      ok = 1'b0;
      unique case (b0)
         CMD_MOTOR: begin
            ok = (b1 <= MAX_MOTOR_DIR);
            res.action = ACT_MOTOR;
            res.motor_dir = b1[2:0];
            res.run_status = status_of_dir(b1[2:0]);
         end
         CMD_SERVO: begin
            ok = (b2 <= max_angle_ff) && (b1 != 8'd0) && (b1 <= MAX_SERVO_IDX);
            res.action = ACT_SERVO;
            res.channel = 3'(b1 - 8'd1);
            res.value = b2;
         end
         CMD_DUTY: begin
            ok = (b1 == 8'd1) || (b1 == 8'd2);
            res.action = ACT_DUTY;
            res.channel = 3'(b1 - 8'd1);
            res.value = 8'({b2, 3'b000} + {b2, 1'b0});
         end
         CMD_LIGHT, CMD_BUZZER: begin
            ok = (b1 <= 8'd1);
            res.action = (b0 == CMD_LIGHT) ? ACT_LIGHT : ACT_BUZZER;
            res.value = b1;
         end
         CMD_IR_LEARN, CMD_IR_SEND: begin
            ok = (b1 < IR_TYPE_LIMIT) && (b2 < IR_NUM_LIMIT);
            res.action = (b0 == CMD_IR_LEARN) ? ACT_IR_LEARN : ACT_IR_SEND;
            res.channel = b1[2:0];
            res.value = b2;
         end
         CMD_MODE: begin
            ok = 1'b1;
            res.action = ACT_MODE;
            res.value = (b1 <= MAX_MODE) ? b1 : 8'd0;
         end
         CMD_STORE: begin
            ok = 1'b1;
            res.action = ACT_STORE;
         end
         default: ok = 1'b0;
      endcase
      if (task_in.kind == KIND_CLOSE && ok) begin
         res.frame_done = 1'b1;
      end else begin
         res = '0;
         res.restart_timeout = (task_in.kind == KIND_OPEN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_angle_ff <= MAX_ANGLE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) max_angle_ff <= csr_wr_data;
         if (task_pop) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (task_pop) begin
         out_ff <= res;
      end
   end

endmodule

/* rtl/framed_command_deframer_decoder_top.sv */
// Framed command deframer/decoder: takes one received byte per transaction and returns one
// result transaction per byte. A 0xFF byte while idle opens a frame (restart_timeout set);
// the next 0xFF closes it, and a frame of exactly three payload bytes is decoded into a
// command (frame_done set only if the command and its arguments are valid). One byte is
// accepted every clock cycle while rsp_tready stays high. A byte goes into the two-entry
// queue at its accept edge; it is decoded from the queue head and its result is loaded
// into the output register once that register is free (empty or being taken). While
// rsp_tready is low, three transactions are held (two queued, one in the output register)
// before req_tready drops. The servo angle limit resets to 180 and is written via csr_.
// depends on fcdd_pkg, fcdd_front, fcdd_fifo, fcdd_back

module framed_command_deframer_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,      // max_servo_angle
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,        // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] frame_done, [1] restart_timeout, [5:2] action, [8:6] motor_dir,
   // [11:9] run_status, [14:12] channel, [22:15] value, [23] zero
   output logic [23:0] rsp_tdata
);
   import fcdd_pkg::*;

   logic       accept;
   logic       fifo_full, fifo_not_empty, fifo_pop;
   task_type   front_task, head_task;
   result_type res;

   assign req_tready = !fifo_full;
   assign accept = req_tvalid && req_tready;

   fcdd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .rx_byte    (req_tdata),
      .task_out   (front_task)
   );

   fcdd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_task),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .not_empty (fifo_not_empty),
      .head      (head_task)
   );

   fcdd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .task_valid  (fifo_not_empty),
      .task_in     (head_task),
      .task_pop    (fifo_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (res)
   );

   assign rsp_tdata = {1'b0, res.value, res.channel, res.run_status, res.motor_dir,
                       res.action, res.restart_timeout, res.frame_done};

endmodule

/* verif/tb_framed_command_deframer_decoder_top.sv */
// testbench for framed_command_deframer_decoder_top: byte stream in, one command result per byte
// a predictor class tracks frames and decodes commands; results are checked field by field
// depends on fcdd_pkg and framed_command_deframer_decoder_top
`timescale 1ns / 1ps

module tb_framed_command_deframer_decoder_top;
   import fcdd_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_BYTES = 200;
   localparam int MAX_REPORTS = 40;

   class command_predictor;
      logic       receiving;
      logic [2:0] byte_count;
      logic [7:0] frame_bytes [3];
      logic [7:0] max_angle;
      result_type expected_cmds [$];
      int         n_errors;
      logic [2:0] run_code [5];

      function new();
         receiving = 1'b0;
         byte_count = '0;
         max_angle = MAX_ANGLE_RESET;
         n_errors = 0;
         run_code = '{3'd4, 3'd3, 3'd5, 3'd2, 3'd1};
      endfunction

      function result_type decode_frame();
         result_type r;
         logic [7:0] b0, b1, b2;
         logic [15:0] duty;
         r = '0;
         b0 = frame_bytes[0];
         b1 = frame_bytes[1];
         b2 = frame_bytes[2];
         case (b0)
            CMD_MOTOR: begin
               if (b1 <= MAX_MOTOR_DIR) begin
                  r.frame_done = 1'b1;
                  r.action = ACT_MOTOR;
                  r.motor_dir = b1[2:0];
                  r.run_status = run_code[b1];
               end
            end
            CMD_SERVO: begin
               if (b2 <= max_angle && b1 >= 8'd1 && b1 <= MAX_SERVO_IDX) begin
                  r.frame_done = 1'b1;
                  r.action = ACT_SERVO;
                  r.channel = 3'(b1 - 8'd1);
                  r.value = b2;
               end
            end
            CMD_DUTY: begin
               if (b1 == 8'd1 || b1 == 8'd2) begin
                  duty = 16'(b2) * 16'd10;
                  r.frame_done = 1'b1;
                  r.action = ACT_DUTY;
                  r.channel = 3'(b1 - 8'd1);
                  r.value = duty[7:0];
               end
            end
            CMD_LIGHT, CMD_BUZZER: begin
               if (b1 <= 8'd1) begin
                  r.frame_done = 1'b1;
                  r.action = (b0 == CMD_LIGHT) ? ACT_LIGHT : ACT_BUZZER;
                  r.value = b1;
               end
            end
            CMD_IR_LEARN, CMD_IR_SEND: begin
               if (b1 < IR_TYPE_LIMIT && b2 < IR_NUM_LIMIT) begin
                  r.frame_done = 1'b1;
                  r.action = (b0 == CMD_IR_LEARN) ? ACT_IR_LEARN : ACT_IR_SEND;
                  r.channel = b1[2:0];
                  r.value = b2;
               end
            end
            CMD_MODE: begin
               r.frame_done = 1'b1;
               r.action = ACT_MODE;
               r.value = (b1 <= MAX_MODE) ? b1 : 8'd0;
            end
            CMD_STORE: begin
               r.frame_done = 1'b1;
               r.action = ACT_STORE;
            end
            default: r = '0;
         endcase
         return r;
      endfunction

      function void take_byte(logic [7:0] b);
         result_type r;
         r = '0;
         if (!receiving) begin
            if (b == MARKER_BYTE) begin
               receiving = 1'b1;
               byte_count = '0;
               r.restart_timeout = 1'b1;
            end
         end else if (b == MARKER_BYTE) begin
            receiving = 1'b0;
            if (byte_count == FRAME_LEN) r = decode_frame();
            byte_count = '0;
         end else begin
            if (byte_count < FRAME_LEN) frame_bytes[byte_count] = b;
            if (byte_count < COUNT_SAT) byte_count++;
         end
         expected_cmds.push_back(r);
      endfunction

      task report(string msg);
         n_errors++;
         if (n_errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_cmd(logic [23:0] d);
         result_type want;
         if (expected_cmds.size() == 0) begin
            report($sformatf("result %h with nothing expected", d));
            return;
         end
         want = expected_cmds.pop_front();
         compare_field("frame_done", 8'(d[0]), 8'(want.frame_done));
         compare_field("restart_timeout", 8'(d[1]), 8'(want.restart_timeout));
         compare_field("action", 8'(d[5:2]), 8'(want.action));
         compare_field("motor_dir", 8'(d[8:6]), 8'(want.motor_dir));
         compare_field("run_status", 8'(d[11:9]), 8'(want.run_status));
         compare_field("channel", 8'(d[14:12]), 8'(want.channel));
         compare_field("value", d[22:15], want.value);
         compare_field("padding", 8'(d[23]), 8'd0);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   command_predictor sb;
   logic [7:0] rx_stream [$];
   bit         hold_pending;
   int         idle_cycles;
   int         sent_bytes;

   framed_command_deframer_decoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #2 clock = ~clock;

   // transaction monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.take_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_cmd(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic logic [7:0] payload_byte();
      return 8'($urandom_range(0, 254));
   endfunction

   function automatic void push_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      rx_stream.push_back(MARKER_BYTE);
      rx_stream.push_back(b0);
      rx_stream.push_back(b1);
      rx_stream.push_back(b2);
      rx_stream.push_back(MARKER_BYTE);
   endfunction

   function automatic void push_random_sequence();
      logic [7:0] cmd_list [9];
      logic [7:0] cmd, b1, b2;
      int kind, n;
      cmd_list = '{CMD_MOTOR, CMD_SERVO, CMD_DUTY, CMD_LIGHT, CMD_BUZZER,
                   CMD_IR_LEARN, CMD_IR_SEND, CMD_MODE, CMD_STORE};
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         cmd = ($urandom_range(0, 7) == 0) ? payload_byte() : cmd_list[$urandom_range(0, 8)];
         b1 = ($urandom_range(0, 4) == 0) ? payload_byte() : 8'($urandom_range(0, 9));
         case ($urandom_range(0, 3))
            0: b2 = 8'($urandom_range(0, 12));
            1: b2 = (sb.max_angle >= 8'd254) ? 8'd254 : sb.max_angle + 8'($urandom_range(0, 1));
            default: b2 = payload_byte();
         endcase
         push_frame(cmd, b1, b2);
      end else if (kind == 7) begin
         // short or long frame
         n = $urandom_range(0, 5);
         if (n == 3) n = 6;
         rx_stream.push_back(MARKER_BYTE);
         repeat (n) rx_stream.push_back(payload_byte());
         rx_stream.push_back(MARKER_BYTE);
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 3)) rx_stream.push_back(payload_byte());
      end else begin
         repeat ($urandom_range(1, 6)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // entered and left at a falling edge
   task automatic send_byte(logic [7:0] b, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_bytes++;
   endtask

   task automatic send_stream(bit burst);
      while (rx_stream.size() != 0) begin
         send_byte(rx_stream.pop_front(), burst ? 0 : $urandom_range(0, 9));
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.expected_cmds.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_angle_limit(logic [7:0] limit);
      drain();
      csr_wr_data <= limit;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.max_angle = limit;
   endtask

   task automatic random_phase();
      int start;
      start = sent_bytes;
      while (sent_bytes - start < PHASE_BYTES) begin
         push_random_sequence();
         send_stream($urandom_range(0, 3) == 0);
      end
   endtask

   // result side ready pattern
   initial begin
      int gap;
      int served;
      bit fast;
      served = 0;
      fast = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = fast ? 0 : $urandom_range(0, 9);
         if (hold_pending) begin
            gap += HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         served++;
         if (served % 32 == 0) fast = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      hold_pending = 1'b0;
      idle_cycles = 0;
      sent_bytes = 0;
      sb = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: motor right, servo at and above the limit, unknown mode,
      // idle byte, short frame, long frame and an unknown command
      push_frame(CMD_MOTOR, 8'd4, 8'd0);
      push_frame(CMD_SERVO, MAX_SERVO_IDX, MAX_ANGLE_RESET);
      push_frame(CMD_SERVO, 8'd1, MAX_ANGLE_RESET + 8'd1);
      push_frame(CMD_MODE, 8'd7, 8'hFE);
      rx_stream.push_back(8'h00);
      rx_stream.push_back(MARKER_BYTE);
      rx_stream.push_back(CMD_LIGHT);
      rx_stream.push_back(MARKER_BYTE);
      push_frame(8'hFE, 8'd0, 8'd0);
      rx_stream.push_back(MARKER_BYTE);
      rx_stream.push_back(CMD_DUTY);
      repeat (3) rx_stream.push_back(8'd1);
      rx_stream.push_back(MARKER_BYTE);
      send_stream(1'b0);

      random_phase();
      set_angle_limit(8'd0);
      hold_pending = 1'b1;
      random_phase();
      set_angle_limit(8'd255);
      random_phase();
      set_angle_limit(8'($urandom_range(1, 254)));
      random_phase();

      drain();
      repeat (10) @(posedge clock);
      if (sb.expected_cmds.size() != 0) sb.report("results still outstanding at end");
      if (sb.n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
